// ===== design/xxtea_pkg.sv =====
package xxtea_pkg;

  localparam int unsigned WORD_W    = 32;
  localparam int unsigned KEY_WORDS = 4;
  localparam int unsigned ROUND_W   = 6;
  localparam int unsigned NUM_W     = 7;
  localparam int unsigned REG_IDX_W = 3;
  localparam int unsigned STATUS_W  = 2;

  localparam logic [WORD_W-1:0] DELTA = 32'h9e3779b9;

  localparam logic [REG_IDX_W-1:0] REG_KEY0 = 3'd0;
  localparam logic [REG_IDX_W-1:0] REG_KEY1 = 3'd1;
  localparam logic [REG_IDX_W-1:0] REG_KEY2 = 3'd2;
  localparam logic [REG_IDX_W-1:0] REG_KEY3 = 3'd3;
  localparam logic [REG_IDX_W-1:0] REG_MODE = 3'd4;

  localparam logic [STATUS_W-1:0] STATUS_OK       = 2'd0;
  localparam logic [STATUS_W-1:0] STATUS_SHORT    = 2'd1;
  localparam logic [STATUS_W-1:0] STATUS_OVERFLOW = 2'd2;

  typedef enum logic [2:0] {
    ST_LOAD,
    ST_PRE0,
    ST_PRE1,
    ST_PRE2,
    ST_RUN,
    ST_EMIT
  } state_e;

  // Number of full rounds over the block: 6 + 52 / n, for n of 2 or more.
  function automatic logic [ROUND_W-1:0] rounds_for(input logic [NUM_W-1:0] n);
    logic [ROUND_W-1:0] q;
    if (n >= 7'd53) begin
      q = 6'd0;
    end else if (n >= 7'd27) begin
      q = 6'd1;
    end else if (n >= 7'd18) begin
      q = 6'd2;
    end else if (n >= 7'd14) begin
      q = 6'd3;
    end else if (n >= 7'd11) begin
      q = 6'd4;
    end else if (n >= 7'd9) begin
      q = 6'd5;
    end else if (n == 7'd8) begin
      q = 6'd6;
    end else if (n == 7'd7) begin
      q = 6'd7;
    end else if (n == 7'd6) begin
      q = 6'd8;
    end else if (n == 7'd5) begin
      q = 6'd10;
    end else if (n == 7'd4) begin
      q = 6'd13;
    end else if (n == 7'd3) begin
      q = 6'd17;
    end else if (n == 7'd2) begin
      q = 6'd26;
    end else begin
      q = 6'd0;
    end
    return 6'd6 + q;
  endfunction

endpackage

// ===== design/xxtea_if.sv =====
interface xxtea_in_if
  import xxtea_pkg::*;
();
  logic              valid;
  logic              ready;
  logic [WORD_W-1:0] data_word;
  logic              last_word;

  modport source (output valid, output data_word, output last_word, input ready);
  modport sink (input valid, input data_word, input last_word, output ready);
endinterface

interface xxtea_out_if
  import xxtea_pkg::*;
();
  logic                valid;
  logic                ready;
  logic [WORD_W-1:0]   result_word;
  logic                final_word;
  logic [STATUS_W-1:0] status;

  modport source (output valid, output result_word, output final_word, output status,
                  input ready);
  modport sink (input valid, input result_word, input final_word, input status,
                output ready);
endinterface

// ===== design/xxtea_word_ram.sv =====
module xxtea_word_ram
  import xxtea_pkg::*;
#(
  parameter int unsigned DEPTH = 64,
  parameter int unsigned AW    = $clog2(DEPTH)
) (
  input  logic              clk_i,
  input  logic              we_i,
  input  logic [AW-1:0]     waddr_i,
  input  logic [WORD_W-1:0] wdata_i,
  input  logic [AW-1:0]     raddr_i,
  output logic [WORD_W-1:0] rdata_o
);

  logic [WORD_W-1:0] mem [DEPTH];
  logic [WORD_W-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  // A read of the entry written at the same edge returns the new word.
  always_ff @(posedge clk_i) begin
    if (we_i && (waddr_i == raddr_i)) begin
      rdata_q <= wdata_i;
    end else begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== design/xxtea_mix.sv =====
module xxtea_mix
  import xxtea_pkg::*;
(
  input  logic              decrypt_i,
  input  logic [WORD_W-1:0] y_i,
  input  logic [WORD_W-1:0] z_i,
  input  logic [WORD_W-1:0] sum_i,
  input  logic [WORD_W-1:0] key_i,
  input  logic [WORD_W-1:0] target_i,
  output logic [WORD_W-1:0] word_o
);

  logic [WORD_W-1:0] a;
  logic [WORD_W-1:0] b;
  logic [WORD_W-1:0] m;

  assign a = ((z_i >> 5) ^ (y_i << 2)) + ((y_i >> 3) ^ (z_i << 4));
  assign b = (sum_i ^ y_i) + (key_i ^ z_i);
  assign m = a ^ b;
  assign word_o = decrypt_i ? (target_i - m) : (target_i + m);

endmodule

// ===== design/xxtea_block_cipher_core.sv =====
// Words of a block are taken one per cycle while the core is in ST_LOAD; a block of
// two or more words then passes the preload states ST_PRE0, ST_PRE1 and ST_PRE2 and
// n * (6 + 52 / n) mixing steps, one per cycle, before its n result words leave
// at up to one per cycle; a one-word block goes straight to its result. The mixing
// rate is set by the single read port of the word memory, one step per cycle.
// Reset clears the control state, the key and the mode; the word memory is not cleared.
module xxtea_block_cipher_core
  import xxtea_pkg::*;
#(
  parameter int unsigned MAX_WORDS = 64
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_we_i,
  input  logic [REG_IDX_W-1:0] cfg_idx_i,
  input  logic [WORD_W-1:0]    cfg_wdata_i,
  xxtea_in_if.sink             req_i,
  xxtea_out_if.source          rsp_o
);

  localparam int unsigned AW = $clog2(MAX_WORDS);
  localparam int unsigned CW = $clog2(MAX_WORDS + 1);

  state_e state_q, state_d;

  logic [WORD_W-1:0]   key_q [KEY_WORDS];
  logic                mode_q;

  logic [CW-1:0]       count_q, count_d;
  logic                ovf_q, ovf_d;
  logic [CW-1:0]       n_q, n_d;
  logic [STATUS_W-1:0] status_q, status_d;
  logic [AW-1:0]       p_q, p_d;
  logic [ROUND_W-1:0]  rnd_q, rnd_d;
  logic [WORD_W-1:0]   sum_q, sum_d;
  logic [WORD_W-1:0]   w_q, w_d;
  logic [WORD_W-1:0]   t_q, t_d;
  logic [AW-1:0]       i_q, i_d;

  logic                ovalid_q, ovalid_d;
  logic                oload;
  logic [WORD_W-1:0]   oword_q;
  logic                ofinal_q;
  logic [STATUS_W-1:0] ostatus_q;

  logic                ram_we;
  logic [AW-1:0]       ram_waddr;
  logic [WORD_W-1:0]   ram_wdata;
  logic [AW-1:0]       ram_raddr;
  logic [WORD_W-1:0]   ram_rdata;

  logic [AW-1:0]       last_idx;
  logic [1:0]          key_sel;
  logic [WORD_W-1:0]   mix_y;
  logic [WORD_W-1:0]   mix_z;
  logic [WORD_W-1:0]   mix_word;

  logic                room;
  logic [CW-1:0]       cnt_new;
  logic                ovf_new;
  logic                wrap;
  logic [AW-1:0]       p_nx;

  function automatic logic [AW-1:0] read_addr(input logic [AW-1:0] p,
                                               input logic [AW-1:0] last,
                                               input logic dec);
    logic [AW-1:0] r;
    if (dec) begin
      r = (p == '0) ? last : p - AW'(1);
    end else begin
      r = (p == last) ? '0 : p + AW'(1);
    end
    return r;
  endfunction

  xxtea_word_ram #(
    .DEPTH (MAX_WORDS),
    .AW    (AW)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  assign last_idx = AW'(n_q - CW'(1));
  assign key_sel  = 2'(p_q) ^ sum_q[3:2];
  assign mix_y    = mode_q ? w_q : ram_rdata;
  assign mix_z    = mode_q ? ram_rdata : w_q;

  xxtea_mix u_mix (
    .decrypt_i (mode_q),
    .y_i       (mix_y),
    .z_i       (mix_z),
    .sum_i     (sum_q),
    .key_i     (key_q[key_sel]),
    .target_i  (t_q),
    .word_o    (mix_word)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int k = 0; k < KEY_WORDS; k++) begin
        key_q[k] <= '0;
      end
      mode_q <= 1'b0;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        REG_KEY0: key_q[0] <= cfg_wdata_i;
        REG_KEY1: key_q[1] <= cfg_wdata_i;
        REG_KEY2: key_q[2] <= cfg_wdata_i;
        REG_KEY3: key_q[3] <= cfg_wdata_i;
        REG_MODE: mode_q   <= cfg_wdata_i[0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= ST_LOAD;
      count_q  <= '0;
      ovf_q    <= 1'b0;
      ovalid_q <= 1'b0;
    end else begin
      state_q  <= state_d;
      count_q  <= count_d;
      ovf_q    <= ovf_d;
      ovalid_q <= ovalid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    n_q      <= n_d;
    status_q <= status_d;
    p_q      <= p_d;
    rnd_q    <= rnd_d;
    sum_q    <= sum_d;
    w_q      <= w_d;
    t_q      <= t_d;
    i_q      <= i_d;
    if (oload) begin
      oword_q   <= ram_rdata;
      ofinal_q  <= (i_q == last_idx);
      ostatus_q <= status_q;
    end
  end

  always_comb begin
    state_d   = state_q;
    count_d   = count_q;
    ovf_d     = ovf_q;
    n_d       = n_q;
    status_d  = status_q;
    p_d       = p_q;
    rnd_d     = rnd_q;
    sum_d     = sum_q;
    w_d       = w_q;
    t_d       = t_q;
    i_d       = i_q;
    oload     = 1'b0;
    ovalid_d  = ovalid_q && !rsp_o.ready;
    ram_we    = 1'b0;
    ram_waddr = AW'(count_q);
    ram_wdata = req_i.data_word;
    ram_raddr = i_q;
    req_i.ready = 1'b0;

    room    = (count_q < CW'(MAX_WORDS));
    cnt_new = count_q + CW'(room);
    ovf_new = ovf_q | !room;
    wrap    = mode_q ? (p_q == '0) : (p_q == last_idx);
    p_nx    = wrap ? (mode_q ? last_idx : '0)
                   : (mode_q ? p_q - AW'(1) : p_q + AW'(1));

    case (state_q)
      ST_LOAD: begin
        req_i.ready = 1'b1;
        if (req_i.valid) begin
          ram_we  = room;
          count_d = cnt_new;
          ovf_d   = ovf_new;
          if (req_i.last_word) begin
            n_d       = cnt_new;
            count_d   = '0;
            ovf_d     = 1'b0;
            i_d       = '0;
            ram_raddr = '0;
            if (cnt_new <= CW'(1)) begin
              status_d = STATUS_SHORT;
              state_d  = ST_EMIT;
            end else begin
              status_d = ovf_new ? STATUS_OVERFLOW : STATUS_OK;
              state_d  = ST_PRE0;
            end
          end
        end
      end
      ST_PRE0: begin
        rnd_d     = rounds_for(NUM_W'(n_q));
        ram_raddr = mode_q ? '0 : last_idx;
        state_d   = ST_PRE1;
      end
      ST_PRE1: begin
        w_d       = ram_rdata;
        ram_raddr = mode_q ? last_idx : '0;
        state_d   = ST_PRE2;
      end
      ST_PRE2: begin
        t_d       = ram_rdata;
        p_d       = mode_q ? last_idx : '0;
        sum_d     = mode_q ? 32'(32'(rnd_q) * DELTA) : DELTA;
        ram_raddr = read_addr(mode_q ? last_idx : '0, last_idx, mode_q);
        state_d   = ST_RUN;
      end
      ST_RUN: begin
        ram_we    = 1'b1;
        ram_waddr = p_q;
        ram_wdata = mix_word;
        w_d       = mix_word;
        t_d       = ram_rdata;
        p_d       = p_nx;
        ram_raddr = read_addr(p_nx, last_idx, mode_q);
        if (wrap) begin
          sum_d = mode_q ? sum_q - DELTA : sum_q + DELTA;
          rnd_d = rnd_q - ROUND_W'(1);
          if (rnd_q == ROUND_W'(1)) begin
            i_d       = '0;
            ram_raddr = '0;
            state_d   = ST_EMIT;
          end
        end
      end
      ST_EMIT: begin
        if (!ovalid_q || rsp_o.ready) begin
          oload    = 1'b1;
          ovalid_d = 1'b1;
          if (i_q == last_idx) begin
            state_d = ST_LOAD;
          end else begin
            i_d       = i_q + AW'(1);
            ram_raddr = i_q + AW'(1);
          end
        end
      end
      default: begin
        state_d = ST_LOAD;
      end
    endcase
  end

  assign rsp_o.valid       = ovalid_q;
  assign rsp_o.result_word = oword_q;
  assign rsp_o.final_word  = ofinal_q;
  assign rsp_o.status      = ostatus_q;

  a_short_is_single: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (rsp_o.valid && (rsp_o.status == STATUS_SHORT)) |-> rsp_o.final_word)
    else $error("single-word result not marked final");

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CW'(MAX_WORDS))
    else $error("word count beyond capacity");

  a_step_in_block: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_RUN) |-> (CW'(p_q) < n_q))
    else $error("mixing step outside the block");

  a_emit_holds_input: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_EMIT) |-> !req_i.ready)
    else $error("request taken while results are pending");

endmodule
